/* rtl/crle_pkg.sv */
// shared types, character codes and helpers for the rate-limited slcan encoder
package crle_pkg;

   // frame record passed from the front end to the serialiser
   typedef struct packed {
      logic [28:0] can_id;
      logic        is_extended;
      logic [3:0]  data_length;
      logic [63:0] payload;
   } frame_type;

   // fixed characters of an slcan line
   localparam logic [7:0] CHAR_STD  = 8'h74;
   localparam logic [7:0] CHAR_EXT  = 8'h54;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_CR   = 8'h0D;

   // longest data field in bytes
   localparam logic [3:0] MAX_LEN = 4'd8;

   // nibble to uppercase ascii hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         hex_char = 8'h30 + wide;
      end else begin
         hex_char = 8'h37 + wide;
      end
   endfunction

endpackage

/* rtl/crle_front.sv */
// front end: accepts frames, looks up the identifier table and decides forward or drop
module crle_front #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_now_ms,
   input  logic [28:0]         req_can_id,
   input  logic                req_is_extended,
   input  logic                req_is_remote,
   input  logic [3:0]          req_data_length,
   input  logic [63:0]         req_payload,
   input  logic [15:0]         min_interval_ms,
   output logic                push_valid,
   input  logic                queue_full,
   output crle_pkg::frame_type push_frame
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_SCAN   = 4'b0010,
      F_DECIDE = 4'b0100,
      F_PUSH   = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;

   // latched frame
   logic [31:0] now_ff, now_in;
   logic [28:0] id_ff, id_in;
   logic        ext_ff, ext_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] pay_ff, pay_in;

   // table bookkeeping
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_time_ff, hit_time_in;

   // table memories
   logic [28:0] ident_mem [TABLE_ENTRIES];
   logic [31:0] time_mem [TABLE_ENTRIES];
   logic [28:0] ident_rd_ff;
   logic [31:0] time_rd_ff;

   logic             rd_en;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic             issuing;
   logic             match;
   logic [31:0]      age;

   assign issuing = (issue_ff < used_ff);
   assign match   = cmp_vld_ff && (ident_rd_ff == id_ff);
   assign age     = now_ff - hit_time_ff;

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      id_in       = id_ff;
      ext_in      = ext_ff;
      len_in      = len_ff;
      pay_in      = pay_ff;
      used_in     = used_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = issue_ff[IDX_W-1:0];
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_time_in = hit_time_ff;
      rd_en       = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = hit_idx_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_is_remote) begin
               now_in   = req_now_ms;
               id_in    = req_can_id;
               ext_in   = req_is_extended;
               len_in   = (req_data_length > crle_pkg::MAX_LEN) ? crle_pkg::MAX_LEN
                                                                : req_data_length;
               pay_in   = req_payload;
               issue_in = '0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            // one table read per cycle, compared in the cycle after
            rd_en      = issuing;
            cmp_vld_in = issuing;
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
            end
            if (match) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_time_in = time_rd_ff;
               cmp_vld_in  = 1'b0;
               state_in    = F_DECIDE;
            end else if (!issuing) begin
               hit_in   = 1'b0;
               state_in = F_DECIDE;
            end
         end
         F_DECIDE: begin
            if (hit_ff) begin
               if (age < {16'h0000, min_interval_ms}) begin
                  state_in = F_IDLE;
               end else begin
                  mem_we   = 1'b1;
                  state_in = F_PUSH;
               end
            end else begin
               // new identifier, tracked only while there is room
               mem_wa   = used_ff[IDX_W-1:0];
               state_in = F_PUSH;
               if (used_ff < ENTRIES) begin
                  mem_we  = 1'b1;
                  used_in = used_ff + 1'b1;
               end
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         used_ff    <= '0;
         issue_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_ff     <= hit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      id_ff       <= id_in;
      ext_ff      <= ext_in;
      len_ff      <= len_in;
      pay_ff      <= pay_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_time_ff <= hit_time_in;
   end

   // identifier and time tables
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ident_mem[mem_wa] <= id_ff;
         time_mem[mem_wa]  <= now_ff;
      end
      if (rd_en) begin
         ident_rd_ff <= ident_mem[issue_ff[IDX_W-1:0]];
         time_rd_ff  <= time_mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign req_stall              = (state_ff != F_IDLE);
   assign push_valid             = (state_ff == F_PUSH);
   assign push_frame.can_id      = id_ff;
   assign push_frame.is_extended = ext_ff;
   assign push_frame.data_length = len_ff;
   assign push_frame.payload     = pay_ff;

endmodule

/* rtl/crle_queue.sv */
// two-entry frame queue between the front end and the serialiser
module crle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crle_pkg::frame_type push_frame,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output crle_pkg::frame_type head
);

   crle_pkg::frame_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

/* rtl/crle_serialiser.sv */
// back end: turns a queued frame into slcan characters, one beat per cycle while rsp_stall is low
module crle_serialiser (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  crle_pkg::frame_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_ascii_char,
   output logic                rsp_last_char
);

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_TYPE = 6'b000010,
      B_ID   = 6'b000100,
      B_LEN  = 6'b001000,
      B_DATA = 6'b010000,
      B_CR   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic        ext_ff, ext_in;
   logic [3:0]  len_ff, len_in;
   logic [31:0] id_sh_ff, id_sh_in;
   logic [63:0] data_sh_ff, data_sh_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;

   logic        advance;
   logic        load;
   logic [63:0] head_swapped;

   assign advance = !valid_ff || !rsp_stall;

   // byte order reversed so byte 0 leaves first, high nibble first
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         head_swapped[63 - 8*b -: 8] = head.payload[8*b +: 8];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ext_in     = ext_ff;
      len_in     = len_ff;
      id_sh_in   = id_sh_ff;
      data_sh_in = data_sh_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      load       = 1'b0;
      if (advance) begin
         valid_in = (state_ff != B_IDLE);
         last_in  = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            load = !queue_empty;
         end
         B_TYPE: begin
            if (advance) begin
               char_in  = ext_ff ? crle_pkg::CHAR_EXT : crle_pkg::CHAR_STD;
               cnt_in   = ext_ff ? 5'd7 : 5'd2;
               state_in = B_ID;
            end
         end
         B_ID: begin
            if (advance) begin
               char_in  = crle_pkg::hex_char(id_sh_ff[31:28]);
               id_sh_in = {id_sh_ff[27:0], 4'h0};
               if (cnt_ff == 5'd0) begin
                  state_in = B_LEN;
               end else begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
         end
         B_LEN: begin
            if (advance) begin
               char_in = crle_pkg::CHAR_ZERO + {4'h0, len_ff};
               cnt_in  = {len_ff, 1'b0} - 5'd1;
               if (len_ff == 4'd0) begin
                  state_in = B_CR;
               end else begin
                  state_in = B_DATA;
               end
            end
         end
         B_DATA: begin
            if (advance) begin
               char_in    = crle_pkg::hex_char(data_sh_ff[63:60]);
               data_sh_in = {data_sh_ff[59:0], 4'h0};
               if (cnt_ff == 5'd0) begin
                  state_in = B_CR;
               end else begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
         end
         B_CR: begin
            if (advance) begin
               char_in  = crle_pkg::CHAR_CR;
               last_in  = 1'b1;
               load     = !queue_empty;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      // take the next frame from the queue
      if (load) begin
         ext_in     = head.is_extended;
         len_in     = head.data_length;
         id_sh_in   = head.is_extended ? {3'b000, head.can_id}
                                       : {1'b0, head.can_id[10:0], 20'h00000};
         data_sh_in = head_swapped;
         state_in   = B_TYPE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ext_ff     <= ext_in;
      len_ff     <= len_in;
      id_sh_ff   <= id_sh_in;
      data_sh_ff <= data_sh_in;
      cnt_ff     <= cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign pop            = load;
   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

/* rtl/can_slcan_rate_limited_encoder.sv */
// top level of the rate-limited slcan frame encoder
//
//  channel | direction | handshake       | beat
//  --------+-----------+-----------------+-----------------------------------------
//  req_    | in        | valid / stall   | one can frame with its timestamp
//  rsp_    | out       | valid / stall   | one ascii character, last on the CR
//  csr_    | in        | valid / ready   | minimum interval in milliseconds
//
// the front end latches a frame, scans the identifiers held in the table one entry per
// cycle through its read port, decides on forward or drop and waits while the queue is
// full to push; a remote frame is swallowed. its line then leaves at one character per
// cycle while rsp_ is unstalled: 6 to 27 characters. a two-frame queue lets the next
// lookup run while a line drains. reset is synchronous and empties the table and the queue.
// a stall on rsp_ holds the output register and backs up through the queue to req_.
module can_slcan_rate_limited_encoder #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic [28:0] req_can_id,
   input  logic        req_is_extended,
   input  logic        req_is_remote,
   input  logic [3:0]  req_data_length,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_min_interval_ms
);

   logic [15:0]         interval_ff;
   logic                push_valid;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   crle_pkg::frame_type push_frame;
   crle_pkg::frame_type head;

   // interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd20;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_min_interval_ms;
      end
   end

   assign csr_ready = 1'b1;

   crle_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_can_id      (req_can_id),
      .req_is_extended (req_is_extended),
      .req_is_remote   (req_is_remote),
      .req_data_length (req_data_length),
      .req_payload     (req_payload),
      .min_interval_ms (interval_ff),
      .push_valid      (push_valid),
      .queue_full      (queue_full),
      .push_frame      (push_frame)
   );

   crle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   crle_serialiser u_serialiser (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

   // a remote frame is swallowed, leaving req_ unstalled in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_is_remote |=> !req_stall)
      else $error("front end busy after a remote frame");

   // only the closing beat carries a carriage return
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> rsp_ascii_char != crle_pkg::CHAR_CR)
      else $error("carriage return inside a line");

   // a popped frame is only taken from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("serialiser popped an empty queue");

   // a pending push waiting on a full queue stays pending
   assert property (@(posedge clock) disable iff (reset)
      push_valid && queue_full |=> push_valid)
      else $error("front end dropped a frame waiting on the queue");

endmodule
